[rtl/mvm_pkg.sv]
// Shared types, constants and helpers for the matrix-vector multiplier.
// No dependencies; the RTL files refer to it by scoped names, the bench files import it.
package mvm_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int SIZE_W   = 6;   // width of the size registers
  localparam int IDX_W    = 5;   // width of row and column indexes
  localparam int DATA_W   = 32;
  localparam int ACC_W    = 64;
  localparam int FRAC_W   = 16;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_MATRIX = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,  // vector load, no result
    KIND_ERROR = 2'd1,  // index out of range
    KIND_MAC   = 2'd2   // matrix element, multiply-accumulate
  } kind_t;

  // Control that travels with one word through the pipeline
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } res_t;

  // Zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r == '0) r = SIZE_W'(1);
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

[rtl/mvm_if.sv]
// Valid/ready channel interfaces for input words and result words.
// Depends on mvm_pkg for widths and codes.
interface mvm_in_if;
  logic                             valid;
  logic                             ready;
  mvm_pkg::cmd_t                    command;
  logic [mvm_pkg::IDX_W-1:0]        row_index;
  logic [mvm_pkg::IDX_W-1:0]        col_index;
  logic signed [mvm_pkg::DATA_W-1:0] element_value;

  modport source (output valid, command, row_index, col_index, element_value,
                  input ready);
  modport sink (input valid, command, row_index, col_index, element_value,
                output ready);
endinterface

interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic [mvm_pkg::IDX_W-1:0]        result_row;
  logic signed [mvm_pkg::DATA_W-1:0] row_value;
  mvm_pkg::status_t                 status;
  logic                             last;

  modport source (output valid, result_row, row_value, status, last,
                  input ready);
  modport sink (input valid, result_row, row_value, status, last,
                output ready);
endinterface

[rtl/mvm_accum.sv]
// Saturating 64-bit row accumulator and result formatting stage.
// Depends on mvm_pkg for ctl_t, res_t and codes.
module mvm_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                in_valid,
  input  mvm_pkg::ctl_t                       in_ctl,
  input  logic signed [mvm_pkg::ACC_W-1:0]    product,
  output logic                                res_valid,
  output mvm_pkg::res_t                       res
);

  logic signed [mvm_pkg::ACC_W-1:0] acc;
  logic                             acc_sat;
  logic                             s3_valid;
  mvm_pkg::ctl_t                    s3_ctl;

  logic signed [mvm_pkg::ACC_W-1:0] base;
  logic                             base_sat;
  logic signed [mvm_pkg::ACC_W-1:0] sum;
  logic                             ovf;
  logic signed [mvm_pkg::ACC_W-1:0] acc_next;
  logic                             acc_sat_next;

  logic signed [mvm_pkg::ACC_W-1:0] shifted;
  logic                             fits;

  always_comb begin
    base     = in_ctl.first_col ? '0 : acc;
    base_sat = in_ctl.first_col ? 1'b0 : acc_sat;
    sum      = base + product;
    ovf      = (base[mvm_pkg::ACC_W-1] == product[mvm_pkg::ACC_W-1]) &&
               (sum[mvm_pkg::ACC_W-1] != base[mvm_pkg::ACC_W-1]);
    if (ovf) begin
      acc_next = base[mvm_pkg::ACC_W-1] ? {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum;
    end
    acc_sat_next = base_sat | ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      acc_sat  <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= in_valid;
      if (in_valid && in_ctl.kind == mvm_pkg::KIND_MAC) begin
        acc     <= acc_next;
        acc_sat <= acc_sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) s3_ctl <= in_ctl;
  end

  // floor shift, then clamp to 32 bits
  always_comb begin
    shifted = acc >>> mvm_pkg::FRAC_W;
    fits    = (&shifted[mvm_pkg::ACC_W-1:mvm_pkg::DATA_W-1]) ||
              !(|shifted[mvm_pkg::ACC_W-1:mvm_pkg::DATA_W-1]);
    res.row = s3_ctl.row;
    if (s3_ctl.kind == mvm_pkg::KIND_ERROR) begin
      res.value  = '0;
      res.status = mvm_pkg::STATUS_RANGE;
      res.last   = 1'b0;
    end else begin
      if (fits) begin
        res.value = shifted[mvm_pkg::DATA_W-1:0];
      end else begin
        res.value = acc[mvm_pkg::ACC_W-1] ? {1'b1, {(mvm_pkg::DATA_W-1){1'b0}}}
                                          : {1'b0, {(mvm_pkg::DATA_W-1){1'b1}}};
      end
      res.status = (acc_sat || !fits) ? mvm_pkg::STATUS_SAT : mvm_pkg::STATUS_OK;
      res.last   = s3_ctl.last_row;
    end
    res_valid = s3_valid &&
                ((s3_ctl.kind == mvm_pkg::KIND_ERROR) ||
                 (s3_ctl.kind == mvm_pkg::KIND_MAC && s3_ctl.last_col));
  end

endmodule

[rtl/matrix_vector_multiply.sv]
// Matrix-vector multiplier, signed Q16.16, y = A * x.
// Throughput: one word per cycle unless a result word waits untaken at the output.
// Stages: vector RAM read, 32x32 multiply, 64-bit saturating accumulate, output.
// The accumulator loop (one add and compare per cycle) sets the word rate.
// Reset (rst, synchronous) clears pipeline valids, accumulator and sizes (1x1);
// vector RAM holds no reset and needs no clearing pass.
module matrix_vector_multiply (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  mvm_pkg::reg_idx_t            cfg_index,
  input  logic [mvm_pkg::SIZE_W-1:0]   cfg_data,
  mvm_in_if.sink                       items,
  mvm_out_if.source                    results
);

  // size registers; the user must write them only while idle, the block does not enforce it
  logic [mvm_pkg::SIZE_W-1:0] num_rows;
  logic [mvm_pkg::SIZE_W-1:0] num_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= mvm_pkg::SIZE_W'(1);
      num_cols <= mvm_pkg::SIZE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mvm_pkg::REG_NUM_ROWS:
          num_rows <= mvm_pkg::clamp_size(cfg_data, mvm_pkg::SIZE_W'(mvm_pkg::MAX_ROWS));
        mvm_pkg::REG_NUM_COLS:
          num_cols <= mvm_pkg::clamp_size(cfg_data, mvm_pkg::SIZE_W'(mvm_pkg::MAX_COLS));
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together; it only stalls when a result word
  // sits in the output register and is not being taken.
  logic out_valid;
  logic advance;
  logic accept;

  assign advance     = !out_valid || results.ready;
  assign items.ready = advance;
  assign accept      = items.valid && advance;

  // range checks on the incoming word
  logic col_ok, row_ok, is_load;
  logic [mvm_pkg::SIZE_W-1:0] col_ext, row_ext;

  assign col_ext = mvm_pkg::SIZE_W'(items.col_index);
  assign row_ext = mvm_pkg::SIZE_W'(items.row_index);
  assign is_load = (items.command == mvm_pkg::CMD_LOAD);
  assign col_ok  = col_ext < num_cols;
  assign row_ok  = row_ext < num_rows;

  mvm_pkg::ctl_t in_ctl;

  always_comb begin
    in_ctl.first_col = (items.col_index == '0);
    in_ctl.last_col  = (col_ext + mvm_pkg::SIZE_W'(1)) == num_cols;
    in_ctl.last_row  = (row_ext + mvm_pkg::SIZE_W'(1)) == num_rows;
    if (is_load) begin
      in_ctl.kind = col_ok ? mvm_pkg::KIND_NONE : mvm_pkg::KIND_ERROR;
      in_ctl.row  = '0;
    end else begin
      in_ctl.kind = (col_ok && row_ok) ? mvm_pkg::KIND_MAC : mvm_pkg::KIND_ERROR;
      in_ctl.row  = items.row_index;
    end
  end

  // Vector RAM: write on a load in range, registered read for the matrix
  // element. A read one word after a write to the same entry already sees
  // the new data, since the write lands at the earlier edge.
  logic signed [mvm_pkg::DATA_W-1:0] vec_mem [mvm_pkg::MAX_COLS];
  logic signed [mvm_pkg::DATA_W-1:0] vec_rdata;

  always_ff @(posedge clk) begin
    if (accept && is_load && col_ok) vec_mem[items.col_index] <= items.element_value;
  end

  always_ff @(posedge clk) begin
    if (advance) vec_rdata <= vec_mem[items.col_index];
  end

  // stage 1: RAM data out, element held alongside
  logic                              s1_valid;
  mvm_pkg::ctl_t                     s1_ctl;
  logic signed [mvm_pkg::DATA_W-1:0] s1_elem;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl  <= in_ctl;
      s1_elem <= items.element_value;
    end
  end

  // stage 2: registered exact product
  logic                             s2_valid;
  mvm_pkg::ctl_t                    s2_ctl;
  logic signed [mvm_pkg::ACC_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (advance) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl  <= s1_ctl;
      s2_prod <= mvm_pkg::ACC_W'(s1_elem) * mvm_pkg::ACC_W'(vec_rdata);
    end
  end

  // stage 3: accumulate and format
  logic          res_valid;
  mvm_pkg::res_t res;

  mvm_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s2_valid),
    .in_ctl   (s2_ctl),
    .product  (s2_prod),
    .res_valid(res_valid),
    .res      (res)
  );

  // output register
  mvm_pkg::res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign results.valid      = out_valid;
  assign results.result_row = out_res.row;
  assign results.row_value  = out_res.value;
  assign results.status     = out_res.status;
  assign results.last       = out_res.last;

endmodule

[tb/sv/mvm_check_pkg.sv]
// Scoreboard for the matrix-vector multiplier: predicts Q16.16 row results
// from accepted words and checks result words in order. Depends on mvm_pkg.
package mvm_check_pkg;
  import mvm_pkg::*;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;

  class row_result_board;
    logic signed [DATA_W-1:0] vector_copy [MAX_COLS];
    logic signed [ACC_W-1:0]  row_sum;
    bit                       sum_clipped;
    int unsigned              rows_in_use;
    int unsigned              cols_in_use;
    res_t                     expected_rows [$];
    int                       failures;
    int                       matched;

    function new();
      foreach (vector_copy[i]) vector_copy[i] = '0;
      row_sum     = '0;
      sum_clipped = 1'b0;
      rows_in_use = 1;
      cols_in_use = 1;
      failures    = 0;
      matched     = 0;
    endfunction

    // 0 reads as 1, anything past the maximum reads as the maximum
    function void set_size(reg_idx_t idx, logic [SIZE_W-1:0] raw);
      int unsigned v;
      v = (raw == '0) ? 1 : int'(raw);
      if (idx == REG_NUM_ROWS) rows_in_use = (v > MAX_ROWS) ? MAX_ROWS : v;
      else cols_in_use = (v > MAX_COLS) ? MAX_COLS : v;
    endfunction

    function void note_word(cmd_t cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic signed [DATA_W-1:0] value);
      res_t                    r;
      logic signed [ACC_W-1:0] prod;
      logic signed [ACC_W-1:0] sum;
      longint                  scaled;
      r.row    = row;
      r.value  = '0;
      r.status = STATUS_RANGE;
      r.last   = 1'b0;
      if (cmd == CMD_LOAD) begin
        if (col >= cols_in_use) begin
          r.row = '0;
          expected_rows.push_back(r);
        end else begin
          vector_copy[col] = value;
        end
        return;
      end
      if (row >= rows_in_use || col >= cols_in_use) begin
        expected_rows.push_back(r);
        return;
      end
      if (col == '0) begin
        row_sum     = '0;
        sum_clipped = 1'b0;
      end
      prod = longint'(value) * longint'(vector_copy[col]);
      sum  = row_sum + prod;
      // signed overflow only when both addends share a sign the sum lost
      if (!row_sum[ACC_W-1] && !prod[ACC_W-1] && sum[ACC_W-1]) begin
        sum         = {1'b0, {(ACC_W-1){1'b1}}};
        sum_clipped = 1'b1;
      end else if (row_sum[ACC_W-1] && prod[ACC_W-1] && !sum[ACC_W-1]) begin
        sum         = {1'b1, {(ACC_W-1){1'b0}}};
        sum_clipped = 1'b1;
      end
      row_sum = sum;
      if (col + 1 != cols_in_use) return;
      scaled   = row_sum >>> FRAC_W;
      r.status = sum_clipped ? STATUS_SAT : STATUS_OK;
      if (scaled > Q16_MAX) begin
        r.value  = Q16_MAX[DATA_W-1:0];
        r.status = STATUS_SAT;
      end else if (scaled < Q16_MIN) begin
        r.value  = Q16_MIN[DATA_W-1:0];
        r.status = STATUS_SAT;
      end else begin
        r.value = scaled[DATA_W-1:0];
      end
      r.last = (row + 1 == rows_in_use);
      expected_rows.push_back(r);
    endfunction

    function void check_row_result(logic [IDX_W-1:0] row, logic signed [DATA_W-1:0] value,
                                   status_t status, logic last);
      res_t want;
      if (expected_rows.size() == 0) begin
        $error("result word with none expected: row %0d value %0d", row, value);
        failures++;
        return;
      end
      want = expected_rows.pop_front();
      if (row !== want.row) begin
        $error("result_row: expected %0d, got %0d", want.row, row);
        failures++;
      end
      if (value !== want.value) begin
        $error("row_value: expected %0d, got %0d", want.value, value);
        failures++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        failures++;
      end
      matched++;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

endpackage

[tb/sv/tb_matrix_vector_multiply.sv]
// Top-level bench for matrix_vector_multiply: drives vector and matrix words,
// random stalls on both channels. Depends on mvm_pkg, mvm_if and mvm_check_pkg.
module tb_matrix_vector_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import mvm_pkg::*;
  import mvm_check_pkg::*;

  localparam int RANDOM_WORDS   = 900;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 8;     // pipeline is four deep; margin on top

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  reg_idx_t          cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  mvm_in_if  item_bus ();
  mvm_out_if result_bus ();

  matrix_vector_multiply u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_bus),
    .results   (result_bus)
  );

  row_result_board board;

  bit idle_in  = 1'b1;  // sender draws gaps between words
  bit idle_out = 1'b1;  // receiver draws stalls after each result word
  int words_sent;
  int size_settings;
  int ready_hold;
  int quiet_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random element: extremes, small magnitudes (results mostly in range),
  // or any 32-bit pattern.
  function automatic logic [DATA_W-1:0] rand_elem();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = '0;
      3, 4, 5: begin
        v = $urandom_range(0, 32'h3_FFFF);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Raw register value; zero and values past 32 exercise the clamp
  function automatic logic [SIZE_W-1:0] draw_size_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_W'($urandom_range(33, 63));
      2:       return SIZE_W'(32);
      3:       return SIZE_W'(1);
      default: return SIZE_W'($urandom_range(2, 6));
    endcase
  endfunction

  // Call at a rising edge; returns at the edge the word is accepted.
  // valid stays high into the next word when no gap is drawn.
  task automatic send_word(cmd_t cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic [DATA_W-1:0] value);
    int gap;
    gap = idle_in ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.command       <= cmd;
    item_bus.row_index     <= row;
    item_bus.col_index     <= col;
    item_bus.element_value <= value;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    board.note_word(cmd, row, col, value);
    words_sent++;
  endtask

  // Stray word: a load at any position or a matrix element at any row/col.
  // In-range matrix hits land out of order on an already loaded column.
  task automatic send_noise();
    if ($urandom_range(0, 1) != 0)
      send_word(CMD_LOAD, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
    else
      send_word(CMD_MATRIX, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
  endtask

  // Drop valid, let every expected word drain, then cover the pipeline
  // depth since in-range loads and mid-row elements leave no trace.
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both size registers on back-to-back cycles; write enable held across
  task automatic write_sizes(logic [SIZE_W-1:0] rows_raw, logic [SIZE_W-1:0] cols_raw);
    cfg_write <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_data  <= rows_raw;
    @(posedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_data  <= cols_raw;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_size(REG_NUM_ROWS, rows_raw);
    board.set_size(REG_NUM_COLS, cols_raw);
    size_settings++;
  endtask

  // Result side: check each accepted word, then draw a stall for ready
  always @(posedge clk) begin
    if (rst) begin
      ready_hold = 0;
      result_bus.ready <= 1'b0;
    end else if (result_bus.valid && result_bus.ready) begin
      board.check_row_result(result_bus.result_row, result_bus.row_value,
                             result_bus.status, result_bus.last);
      ready_hold = idle_out ? $urandom_range(0, 7) : 0;
      result_bus.ready <= (ready_hold == 0);
    end else if (ready_hold > 0) begin
      ready_hold--;
      result_bus.ready <= (ready_hold == 0);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // Watchdog: no word moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no word accepted", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int rows;
    int cols;
    int n_rows;
    int start;
    int base;
    int phase;
    logic [SIZE_W-1:0] rows_raw;
    logic [SIZE_W-1:0] cols_raw;

    board                  = new();
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = REG_NUM_ROWS;
    cfg_data               = '0;
    item_bus.valid         = 1'b0;
    item_bus.command       = CMD_LOAD;
    item_bus.row_index     = '0;
    item_bus.col_index     = '0;
    item_bus.element_value = '0;
    result_bus.ready       = 1'b0;
    words_sent             = 0;
    size_settings          = 0;
    quiet_cycles           = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // Reset sizes are 1x1: one column, and the only row is also the last
    send_word(CMD_LOAD, 5'd0, 5'd0, 32'h0001_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd0, 32'h0003_0000);
    send_word(CMD_LOAD, 5'd0, 5'd1, 32'h1234_5678);     // past num_cols: error word
    wait_idle();

    write_sizes(SIZE_W'(3), SIZE_W'(3));
    send_word(CMD_LOAD, 5'd31, 5'd0, 32'h8000_0000);
    send_word(CMD_LOAD, 5'd0, 5'd1, 32'h8000_0000);
    send_word(CMD_LOAD, 5'd0, 5'd2, 32'h7FFF_FFFF);
    send_word(CMD_LOAD, 5'd0, 5'd3, 32'hFFFF_FFFF);     // out of range, store untouched
    // Two products of 2^62 overflow the accumulator upward
    send_word(CMD_MATRIX, 5'd0, 5'd0, 32'h8000_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd1, 32'h8000_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd2, 32'h0000_0000);
    // Three near -2^62 products overflow downward
    send_word(CMD_MATRIX, 5'd1, 5'd0, 32'h7FFF_FFFF);
    send_word(CMD_MATRIX, 5'd1, 5'd1, 32'h7FFF_FFFF);
    send_word(CMD_MATRIX, 5'd1, 5'd2, 32'h8000_0000);
    // Clean row, last row flag set
    send_word(CMD_MATRIX, 5'd2, 5'd0, 32'h0000_0000);
    send_word(CMD_MATRIX, 5'd2, 5'd1, 32'h0000_0000);
    send_word(CMD_MATRIX, 5'd2, 5'd2, 32'h0001_0000);
    // 2.0 * -32768.0 fits the accumulator but not the 32-bit result
    send_word(CMD_MATRIX, 5'd0, 5'd0, 32'h0002_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd1, 32'h0000_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd2, 32'h0000_0000);
    // Row and column out of range
    send_word(CMD_MATRIX, 5'd31, 5'd0, 32'h0001_0000);
    send_word(CMD_MATRIX, 5'd0, 5'd31, 32'h0001_0000);
    // Out of order: no column 0, result tagged with the row of the last column;
    // -1 LSB times max gives a negative fraction for the floor shift
    send_word(CMD_MATRIX, 5'd2, 5'd1, 32'h0000_0001);
    send_word(CMD_MATRIX, 5'd1, 5'd2, 32'hFFFF_FFFF);
    wait_idle();

    // ---- random phases ----
    // Each phase: new sizes, full vector load, then whole rows in row-major
    // order with the occasional stray word mixed in.
    base  = words_sent;
    phase = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      idle_in  = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      wait_idle();
      case (phase)
        0:       begin rows_raw = SIZE_W'(63); cols_raw = '0;          end
        1:       begin rows_raw = '0;          cols_raw = SIZE_W'(32); end
        default: begin rows_raw = draw_size_raw(); cols_raw = draw_size_raw(); end
      endcase
      write_sizes(rows_raw, cols_raw);
      rows = board.rows_in_use;
      cols = board.cols_in_use;

      for (int c = 0; c < cols; c++)
        send_word(CMD_LOAD, IDX_W'($urandom), IDX_W'(c), rand_elem());

      n_rows = $urandom_range(1, 6);
      start  = $urandom_range(0, rows - 1);
      for (int k = 0; k < n_rows; k++) begin
        for (int c = 0; c < cols; c++) begin
          if ($urandom_range(0, 19) == 0) send_noise();
          send_word(CMD_MATRIX, IDX_W'((start + k) % rows), IDX_W'(c), rand_elem());
        end
      end
      phase++;
    end

    // ---- drain and report ----
    wait_idle();
    if (board.pending() != 0) begin
      $error("%0d expected result words never arrived", board.pending());
      board.failures++;
    end
    $display("Run covered %0d input words and %0d checked result words", words_sent,
             board.matched);
    $display("across %0d size settings, including clamped register values", size_settings);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mvm_pkg.sv
rtl/mvm_if.sv
rtl/mvm_accum.sv
rtl/matrix_vector_multiply.sv
tb/sv/mvm_check_pkg.sv
tb/sv/tb_matrix_vector_multiply.sv
